@@ rtl/core/drm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_pkg
// Shared constants and controller/datapath interface types for the
// duplicate read marker.
// ----------------------------------------------------------------------------
package drm_pkg;

    localparam int MAX_REPS         = 16;
    localparam int WORDS_PER_RECORD = 8;
    localparam int STORE_DEPTH      = MAX_REPS * WORDS_PER_RECORD;

    localparam int REP_W   = (MAX_REPS > 1) ? $clog2(MAX_REPS) : 1;
    localparam int CNT_W   = $clog2(MAX_REPS + 1);
    localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int WIDX_W  = 3;
    localparam int BMAP_W  = 64;
    localparam int TID_W   = 32;
    localparam int START_W = 31;
    localparam int ID_W    = 32;
    localparam int TOTAL_W = 32;

    localparam int S_TDATA_W = 296;
    localparam int M_TDATA_W = 72;

    typedef struct packed {
        logic capture;
        logic prep;
        logic scan;
        logic write;
        logic finish;
    } drm_cmd_t;

    typedef struct packed {
        logic skip;
        logic is_last;
        logic scan_done;
        logic out_free;
    } drm_status_t;

endpackage

@@ rtl/core/duplicate_read_marker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_read_marker
// Marks duplicate alignment records by comparing call bitmaps against the
// stored representatives of the current position bin.
// ----------------------------------------------------------------------------
// Each word (one bitmap word of one record) is accepted in IDLE and then
// passes through PREP and SCAN; the last word of a record also passes
// through FIN, where the record result is issued. In SCAN the single read
// port of the representative store is visited once per representative
// stored in the bin (0 to 16), and each read is registered and then
// compared. A new word is not taken until the last one is through. A
// result waiting on the output does not block input until the next record
// result is due. The store is not cleared after reset; reading a store
// word that was never written gives an arbitrary value.
module duplicate_read_marker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tid_first[31:0], tid_second[63:32], start_first[94:64],
    // start_second[125:95], word_index[128:126], meth_word[192:129],
    // unmeth_word[256:193], record_id[288:257], zero[295:289]
    input  logic [drm_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_record_id[31:0], is_duplicate[32], store_overflow[33],
    // duplicate_total[65:34], zero[71:66]
    output logic [drm_pkg::M_TDATA_W-1:0]   m_tdata
);

    drm_pkg::drm_cmd_t    cmd;
    drm_pkg::drm_status_t status;

    logic [drm_pkg::ID_W-1:0]    out_record_id;
    logic                        is_duplicate;
    logic                        store_overflow;
    logic [drm_pkg::TOTAL_W-1:0] duplicate_total;

    drm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    drm_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .tid_first       (s_tdata[31:0]),
        .tid_second      (s_tdata[63:32]),
        .start_first     (s_tdata[94:64]),
        .start_second    (s_tdata[125:95]),
        .word_index      (s_tdata[128:126]),
        .meth_word       (s_tdata[192:129]),
        .unmeth_word     (s_tdata[256:193]),
        .record_id       (s_tdata[288:257]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_record_id   (out_record_id),
        .is_duplicate    (is_duplicate),
        .store_overflow  (store_overflow),
        .duplicate_total (duplicate_total)
    );

    assign m_tdata = {6'd0, duplicate_total, store_overflow, is_duplicate, out_record_id};

    a_finish_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_tvalid || m_tready))
        else $error("result issued while output slot occupied");

    a_finish_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("result not presented after finish");

    a_accept_no_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!cmd.scan && !s_tready))
        else $error("scan or accept right after accepting a word");

    a_ovf_not_dup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> !(m_tdata[32] && m_tdata[33]))
        else $error("result both duplicate and overflow");

endmodule

@@ rtl/core/drm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_ctrl
// Sequencer: capture a word, check the bin key, scan the stored
// representatives, store the word and issue the record result.
// ----------------------------------------------------------------------------
module drm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  drm_pkg::drm_status_t status,
    output drm_pkg::drm_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (status.skip) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.prep   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    cmd.write  = 1'b1;
                    state_next = status.is_last ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/drm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_dp
// Datapath: captured word, bin key, representative store, match flags,
// counters and the result register.
// ----------------------------------------------------------------------------
module drm_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  drm_pkg::drm_cmd_t                 cmd,
    output drm_pkg::drm_status_t              status,
    input  logic [drm_pkg::TID_W-1:0]         tid_first,
    input  logic [drm_pkg::TID_W-1:0]         tid_second,
    input  logic [drm_pkg::START_W-1:0]       start_first,
    input  logic [drm_pkg::START_W-1:0]       start_second,
    input  logic [drm_pkg::WIDX_W-1:0]        word_index,
    input  logic [drm_pkg::BMAP_W-1:0]        meth_word,
    input  logic [drm_pkg::BMAP_W-1:0]        unmeth_word,
    input  logic [drm_pkg::ID_W-1:0]          record_id,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [drm_pkg::ID_W-1:0]          out_record_id,
    output logic                              is_duplicate,
    output logic                              store_overflow,
    output logic [drm_pkg::TOTAL_W-1:0]       duplicate_total
);

    // captured word
    logic [drm_pkg::TID_W-1:0]   tf_reg, ts_reg;
    logic [drm_pkg::START_W-1:0] sf_reg, ss_reg;
    logic [drm_pkg::WIDX_W-1:0]  w_reg;
    logic [drm_pkg::BMAP_W-1:0]  m_reg, u_reg;
    logic [drm_pkg::ID_W-1:0]    id_reg;

    // bin state
    logic [drm_pkg::TID_W-1:0]   bin_tf_reg, bin_ts_reg;
    logic [drm_pkg::START_W-1:0] bin_sf_reg, bin_ss_reg;
    logic                        bin_open_reg;
    logic [drm_pkg::CNT_W-1:0]   count_reg;
    logic [drm_pkg::CNT_W-1:0]   count_prep;
    logic [drm_pkg::MAX_REPS-1:0] match_reg;
    logic [drm_pkg::MAX_REPS-1:0] match_next;
    logic [drm_pkg::TOTAL_W-1:0] total_reg;

    // scan pipeline
    logic [drm_pkg::CNT_W-1:0]   rd_idx_reg;
    logic                        cmp_valid_reg;
    logic [drm_pkg::REP_W-1:0]   cmp_idx_reg;
    logic                        rd_more;
    logic [drm_pkg::ADDR_W-1:0]  rd_addr;
    logic [drm_pkg::ADDR_W-1:0]  wr_addr;
    logic                        room;
    logic                        new_bin;
    logic                        dup;

    // representative store: {meth, unmeth}
    logic [2*drm_pkg::BMAP_W-1:0] store_mem [drm_pkg::STORE_DEPTH];
    logic [2*drm_pkg::BMAP_W-1:0] rd_data_reg;

    // result register
    logic                        out_valid_reg;
    logic [drm_pkg::ID_W-1:0]    out_id_reg;
    logic                        out_dup_reg;
    logic                        out_ovf_reg;

    assign new_bin = !bin_open_reg || (tf_reg != bin_tf_reg) || (ts_reg != bin_ts_reg)
                     || (sf_reg != bin_sf_reg) || (ss_reg != bin_ss_reg);
    assign count_prep = (w_reg == '0 && new_bin) ? '0 : count_reg;
    assign rd_more = rd_idx_reg < count_reg;
    assign room    = count_reg < drm_pkg::CNT_W'(drm_pkg::MAX_REPS);
    assign rd_addr = drm_pkg::ADDR_W'(rd_idx_reg[drm_pkg::REP_W-1:0])
                     * drm_pkg::ADDR_W'(drm_pkg::WORDS_PER_RECORD)
                     + drm_pkg::ADDR_W'(w_reg);
    assign wr_addr = drm_pkg::ADDR_W'(count_reg[drm_pkg::REP_W-1:0])
                     * drm_pkg::ADDR_W'(drm_pkg::WORDS_PER_RECORD)
                     + drm_pkg::ADDR_W'(w_reg);
    assign dup = |match_reg;

    assign status.skip      = 32'(w_reg) >= drm_pkg::WORDS_PER_RECORD;
    assign status.is_last   = 32'(w_reg) == drm_pkg::WORDS_PER_RECORD - 1;
    assign status.scan_done = !rd_more && !cmp_valid_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    always_comb begin
        match_next = match_reg;
        if (cmd.prep && w_reg == '0) begin
            for (int i = 0; i < drm_pkg::MAX_REPS; i++) begin
                match_next[i] = i < int'(count_prep);
            end
        end
        if (cmd.scan && cmp_valid_reg) begin
            if (((m_reg ^ rd_data_reg[2*drm_pkg::BMAP_W-1:drm_pkg::BMAP_W])
                 & (u_reg ^ rd_data_reg[drm_pkg::BMAP_W-1:0])) != '0) begin
                match_next[cmp_idx_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            tf_reg <= tid_first;
            ts_reg <= tid_second;
            sf_reg <= start_first;
            ss_reg <= start_second;
            w_reg  <= word_index;
            m_reg  <= meth_word;
            u_reg  <= unmeth_word;
            id_reg <= record_id;
        end
        if (cmd.prep && w_reg == '0 && new_bin) begin
            bin_tf_reg <= tf_reg;
            bin_ts_reg <= ts_reg;
            bin_sf_reg <= sf_reg;
            bin_ss_reg <= ss_reg;
        end
        if (cmd.scan && rd_more) begin
            rd_data_reg <= store_mem[rd_addr];
            cmp_idx_reg <= rd_idx_reg[drm_pkg::REP_W-1:0];
        end
        if (cmd.write && room) begin
            store_mem[wr_addr] <= {m_reg, u_reg};
        end
        if (cmd.finish) begin
            out_id_reg  <= id_reg;
            out_dup_reg <= dup;
            out_ovf_reg <= !dup && !room;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_open_reg  <= 1'b0;
            count_reg     <= '0;
            match_reg     <= '0;
            total_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            match_reg     <= match_next;
            cmp_valid_reg <= cmd.scan && rd_more;
            if (cmd.prep) begin
                rd_idx_reg <= '0;
                count_reg  <= count_prep;
                if (w_reg == '0) begin
                    bin_open_reg <= 1'b1;
                end
            end else if (cmd.scan && rd_more) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmd.finish) begin
                if (dup) begin
                    if (total_reg != '1) begin
                        total_reg <= total_reg + 1'b1;
                    end
                end else if (room) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign out_record_id   = out_id_reg;
    assign is_duplicate    = out_dup_reg;
    assign store_overflow  = out_ovf_reg;
    assign duplicate_total = total_reg;

endmodule
